FILE: design/rarmi_pkg.sv
// ============================================================================
// rarmi_pkg
// Shared sizes, operation codes and the command/token structs that the
// controller and the cell row pass between them.
// ============================================================================
package rarmi_pkg;

    // Array geometry
    localparam int N_POS  = 256;
    localparam int IDX_W  = 8;
    localparam int VAL_W  = 64;
    localparam int SIZE_W = 9;
    localparam int CNT_W  = $clog2(N_POS + 1);

    // APB register map (single register)
    localparam int ADDR_W  = 2;
    localparam int PDATA_W = 32;
    localparam logic [ADDR_W-1:0] ADDR_SIZE_IN_USE = '0;

    // Operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [VAL_W-1:0] LARGEST_VALUE = {1'b0, {(VAL_W-1){1'b1}}};

    // Command broadcast to every cell
    typedef struct packed {
        logic             load_en;
        logic             add_en;
        logic             range_ok;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [VAL_W-1:0] value;
    } t_cmd;

    // Running minimum handed from cell to cell
    typedef struct packed {
        logic             found;
        logic [VAL_W-1:0] best;
        logic [IDX_W-1:0] pos;
    } t_tok;

    localparam t_tok TOK_EMPTY = '{found: 1'b0, best: LARGEST_VALUE, pos: '0};

endpackage

FILE: design/rarmi_cell.sv
// ============================================================================
// rarmi_cell
// One array position: holds its value, applies loads and adds from the
// broadcast command, and folds its value into the passing minimum token.
// ============================================================================
module rarmi_cell
    import rarmi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [IDX_W-1:0] i_index,
    input  t_cmd             i_cmd,
    input  t_tok             i_tok,
    output t_tok             o_tok
);

    logic [VAL_W-1:0] r_value;
    t_tok             r_tok;
    logic             in_range;
    logic             better;

    assign in_range = i_cmd.range_ok && (i_index >= i_cmd.lo) && (i_index <= i_cmd.hi);
    assign better   = !i_tok.found || ($signed(r_value) < $signed(i_tok.best));

    // Update the stored value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else if (in_range && i_cmd.load_en) begin
            r_value <= i_cmd.value;
        end else if (in_range && i_cmd.add_en) begin
            r_value <= r_value + i_cmd.value;
        end
    end

    // Advance the token, taking this position when it is strictly smaller
    always_ff @(posedge i_clk) begin
        if (in_range && better) begin
            r_tok <= '{found: 1'b1, best: r_value, pos: i_index};
        end else begin
            r_tok <= i_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

FILE: design/rarmi_ctrl.sv
// ============================================================================
// rarmi_ctrl
// Input handshake, range clamping, configuration register and the result
// register. Issues commands to the cell row and waits out the token sweep.
// ============================================================================
module rarmi_ctrl
    import rarmi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input transactions
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic [IDX_W-1:0]   i_range_left,
    input  logic [IDX_W-1:0]   i_range_right,
    input  logic [VAL_W-1:0]   i_operand_value,
    // result transactions
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VAL_W-1:0]   o_min_value,
    output logic [IDX_W-1:0]   o_min_position,
    output logic               o_range_empty,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // cell row
    output t_cmd               o_cmd,
    input  t_tok               i_tok
);

    typedef enum logic {ST_IDLE, ST_QUERY} t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [SIZE_W-1:0] r_size;
    t_cmd              r_cmd;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_min_value;
    logic [IDX_W-1:0]  r_min_position;
    logic              r_range_empty;

    t_state            n_state;
    logic [CNT_W-1:0]  n_cnt;
    logic [SIZE_W-1:0] n_size;
    t_cmd              n_cmd;
    logic              n_out_valid;
    logic [VAL_W-1:0]  n_min_value;
    logic [IDX_W-1:0]  n_min_position;
    logic              n_range_empty;

    logic [CNT_W-1:0]  eff_n;
    logic [IDX_W-1:0]  hi_clamp;
    logic              cfg_wr;
    logic              take_in;
    logic              out_free;

    // Clamp the window size to 1..N_POS
    always_comb begin
        if (r_size == '0) begin
            eff_n = CNT_W'(1);
        end else if (CNT_W'(r_size) > CNT_W'(N_POS)) begin
            eff_n = CNT_W'(N_POS);
        end else begin
            eff_n = CNT_W'(r_size);
        end
    end

    assign hi_clamp = (CNT_W'(i_range_right) >= eff_n) ? IDX_W'(eff_n - CNT_W'(1))
                                                       : i_range_right;

    assign cfg_wr   = psel && penable && pwrite && pready && (paddr == ADDR_SIZE_IN_USE);
    assign take_in  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Next state, commands, configuration and result register
    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_size         = r_size;
        n_cmd          = r_cmd;
        n_cmd.load_en  = 1'b0;
        n_cmd.add_en   = 1'b0;
        n_out_valid    = r_out_valid;
        n_min_value    = r_min_value;
        n_min_position = r_min_position;
        n_range_empty  = r_range_empty;
        if (cfg_wr) begin
            n_size = pwdata[SIZE_W-1:0];
        end
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (take_in) begin
                    n_cmd.value    = i_operand_value;
                    n_cmd.lo       = i_range_left;
                    n_cmd.hi       = hi_clamp;
                    n_cmd.range_ok = (i_range_left <= hi_clamp);
                    case (i_operation)
                        OP_LOAD: begin
                            n_cmd.load_en  = 1'b1;
                            n_cmd.hi       = i_range_left;
                            n_cmd.range_ok = (CNT_W'(i_range_left) < eff_n);
                        end
                        OP_ADD: begin
                            n_cmd.add_en = 1'b1;
                        end
                        OP_QUERY: begin
                            n_state = ST_QUERY;
                            n_cnt   = '0;
                        end
                        default: begin
                            n_cmd.range_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_QUERY: begin
                if (r_cnt != CNT_W'(N_POS)) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (out_free) begin
                    n_min_value    = i_tok.best;
                    n_min_position = i_tok.pos;
                    n_range_empty  = !i_tok.found;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_cnt          <= '0;
            r_size         <= SIZE_W'(N_POS);
            r_cmd          <= '0;
            r_out_valid    <= 1'b0;
            r_min_value    <= '0;
            r_min_position <= '0;
            r_range_empty  <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cnt          <= n_cnt;
            r_size         <= n_size;
            r_cmd          <= n_cmd;
            r_out_valid    <= n_out_valid;
            r_min_value    <= n_min_value;
            r_min_position <= n_min_position;
            r_range_empty  <= n_range_empty;
        end
    end

    assign o_ready        = (r_state == ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_min_value    = r_min_value;
    assign o_min_position = r_min_position;
    assign o_range_empty  = r_range_empty;
    assign o_cmd          = r_cmd;
    assign prdata         = PDATA_W'(r_size);
    assign pready         = 1'b1;

    // A query holds off the input until its sweep is done
    a_query_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take_in && (i_operation == OP_QUERY) |=> !o_ready)
        else $error("input taken during query sweep");

    // Load and add never fire together
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_cmd.load_en, r_cmd.add_en}))
        else $error("load and add issued together");

    // A result only appears at the end of a query sweep
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_QUERY) && $past(r_cnt == CNT_W'(N_POS)))
        else $error("result raised outside a query sweep");

    // Commands are never issued while a sweep is running
    a_no_cmd_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_QUERY) && (r_cnt != '0) |-> !r_cmd.load_en && !r_cmd.add_en)
        else $error("cell command during query sweep");

endmodule

FILE: design/range_add_range_min_index.sv
// ============================================================================
// range_add_range_min_index
// Signed 64-bit array with point load, range add and range-minimum query,
// built as a row of one-position cells with a minimum token passed along it.
// ============================================================================
// Usage:
//   Input channel (i_valid/o_ready) carries one operation per transaction:
//   load one position, add to a range, or query the minimum of a range.
//   Result channel (o_valid/i_ready) carries one transaction per query only.
//   A load or an add is registered as a command that all in-range cells
//   apply in parallel; the input stays ready, so the next transaction is
//   taken in the following cycle. A query sweeps a token from cell 0
//   through all 256 cells, one cell per clock, and its result is
//   registered at the end of the sweep; the input is held off until the
//   result is registered, so no new transaction is taken during a query.
//   The result sits in an output register; while the receiver stalls the
//   next transactions are still taken, and a following query waits at the
//   end of its sweep, with the input held off, until the register is free.
//   The APB register size_in_use (address 0) sets the active window.
//   Reset clears all stored values to zero and sets size_in_use to 256;
//   the block is ready right after reset.
// ============================================================================
module range_add_range_min_index
    import rarmi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_operation,
    input  logic [IDX_W-1:0]   i_range_left,
    input  logic [IDX_W-1:0]   i_range_right,
    input  logic [VAL_W-1:0]   i_operand_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [VAL_W-1:0]   o_min_value,
    output logic [IDX_W-1:0]   o_min_position,
    output logic               o_range_empty,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cmd w_cmd;
    t_tok w_tok [N_POS+1];

    // Feed an empty token into the head of the row
    assign w_tok[0] = TOK_EMPTY;

    rarmi_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_range_left    (i_range_left),
        .i_range_right   (i_range_right),
        .i_operand_value (i_operand_value),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_min_value     (o_min_value),
        .o_min_position  (o_min_position),
        .o_range_empty   (o_range_empty),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_cmd           (w_cmd),
        .i_tok           (w_tok[N_POS])
    );

    // Row of cells, one per position
    for (genvar g = 0; g < N_POS; g++) begin : g_cell
        rarmi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (IDX_W'(g)),
            .i_cmd   (w_cmd),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

endmodule
